// ===== sv/rpt_pkg.sv =====
// shared types and constants for the rectangle placement table
package rpt_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int COORD_BITS  = 12;
	localparam int ID_BITS     = 8;
	localparam int COUNT_BITS  = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		CMD_PLACE  = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_MOVE   = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OVERLAP = 2'd1,
		ST_MISS    = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// command as seen by every cell
	typedef struct packed {
		cmd_t                  cmd;
		logic [ID_BITS-1:0]    id;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
	} bcast_t;

	typedef struct packed {
		logic find_en;
		logic commit_en;
	} ctrl_t;

	// selected cell contents, zero from cells that are not selected
	typedef struct packed {
		logic [ID_BITS-1:0]    id;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
	} sel_info_t;

	function automatic logic spans_meet(
		input logic [COORD_BITS-1:0] a, input logic [COORD_BITS-1:0] alen,
		input logic [COORD_BITS-1:0] b, input logic [COORD_BITS-1:0] blen);
		logic [COORD_BITS:0] a_end;
		logic [COORD_BITS:0] b_end;
		a_end = {1'b0, a} + {1'b0, alen};
		b_end = {1'b0, b} + {1'b0, blen};
		return ({1'b0, a} < b_end) && ({1'b0, b} < a_end);
	endfunction

endpackage

// ===== sv/rpt_cell.sv =====
// one table slot: stored rectangle, match logic and priority chain link
module rpt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  rpt_pkg::bcast_t     bcast,
	input  rpt_pkg::ctrl_t      ctrl,
	input  logic                chain_in,
	output logic                chain_out,
	output logic                ovl,
	output rpt_pkg::sel_info_t  sel_info
);

	logic                           valid_q;
	logic                           sel_q;
	logic [rpt_pkg::ID_BITS-1:0]    id_q;
	logic [rpt_pkg::COORD_BITS-1:0] x_q, y_q, w_q, h_q;
	logic                           want;
	logic                           take;
	logic                           covers;
	logic [rpt_pkg::COORD_BITS:0]   x_end, y_end;

	always_comb begin
		x_end  = {1'b0, x_q} + {1'b0, w_q};
		y_end  = {1'b0, y_q} + {1'b0, h_q};
		covers = ({1'b0, bcast.x} >= {1'b0, x_q}) && ({1'b0, bcast.x} < x_end) &&
			({1'b0, bcast.y} >= {1'b0, y_q}) && ({1'b0, bcast.y} < y_end);
		case (bcast.cmd)
			rpt_pkg::CMD_PLACE: want = !valid_q;
			rpt_pkg::CMD_QUERY: want = valid_q && covers;
			default:            want = valid_q && (id_q == bcast.id);
		endcase
	end

	// first wanting cell in slot order takes the selection
	assign chain_out = chain_in || want;
	assign take      = want && !chain_in;

	assign ovl = valid_q && !sel_q &&
		rpt_pkg::spans_meet(bcast.x, bcast.w, x_q, w_q) &&
		rpt_pkg::spans_meet(bcast.y, bcast.h, y_q, h_q);

	// contents of the cell that wins the chain this cycle
	assign sel_info.id = take ? id_q : '0;
	assign sel_info.w  = take ? w_q  : '0;
	assign sel_info.h  = take ? h_q  : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (ctrl.find_en) begin
				sel_q <= take;
			end
			if (ctrl.commit_en && sel_q) begin
				case (bcast.cmd)
					rpt_pkg::CMD_PLACE:  valid_q <= 1'b1;
					rpt_pkg::CMD_REMOVE: valid_q <= 1'b0;
					default:             valid_q <= valid_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit_en && sel_q) begin
			if (bcast.cmd == rpt_pkg::CMD_PLACE) begin
				id_q <= bcast.id;
				w_q  <= bcast.w;
				h_q  <= bcast.h;
			end
			if (bcast.cmd == rpt_pkg::CMD_PLACE || bcast.cmd == rpt_pkg::CMD_MOVE) begin
				x_q <= bcast.x;
				y_q <= bcast.y;
			end
		end
	end

endmodule

// ===== sv/rect_placement_table.sv =====
// top level: command sequencer over the row of slot cells
// Each command goes through the idle, find, check and commit states in turn:
// the transfer in idle latches the command, find lets every cell compare and
// the priority chain through the cells pick the lowest matching slot, check
// runs the overlap test of the other cells against the (possibly moved)
// rectangle, and commit writes the selected cell and registers the result.
// The next command is taken only once the sequencer is back in idle.
// The chain of 64 cells sets the length of the find cycle. A result
// not yet taken holds back only the final write of the next command.
module rect_placement_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     cmd,
	input  logic [rpt_pkg::ID_BITS-1:0]    object_id,
	input  logic [rpt_pkg::COORD_BITS-1:0] rect_width,
	input  logic [rpt_pkg::COORD_BITS-1:0] rect_height,
	input  logic [rpt_pkg::COORD_BITS-1:0] pos_x,
	input  logic [rpt_pkg::COORD_BITS-1:0] pos_y,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [rpt_pkg::ID_BITS-1:0]    hit_id,
	output logic [rpt_pkg::COUNT_BITS-1:0] entry_count
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_FIND   = 4'b0010,
		S_CHECK  = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t                         state_q;
	rpt_pkg::bcast_t                bcast_q;
	rpt_pkg::ctrl_t                 ctrl;
	logic [rpt_pkg::MAX_ENTRIES:0]  chain;
	logic [rpt_pkg::MAX_ENTRIES-1:0] ovl_vec;
	rpt_pkg::sel_info_t             info_vec [rpt_pkg::MAX_ENTRIES];
	rpt_pkg::sel_info_t             sel_or;
	logic                           found_q;
	logic                           ovl_q;
	logic [rpt_pkg::ID_BITS-1:0]    sel_id_q;
	logic                           out_valid_q;
	rpt_pkg::status_t               status_q;
	logic [rpt_pkg::ID_BITS-1:0]    hit_id_q;
	logic [rpt_pkg::COUNT_BITS-1:0] count_q;
	logic                           go;
	rpt_pkg::status_t               status_d;
	logic                           place_ok;
	logic                           remove_ok;

	assign chain[0] = 1'b0;

	for (genvar i = 0; i < rpt_pkg::MAX_ENTRIES; i++) begin : g_cell
		rpt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bcast     (bcast_q),
			.ctrl      (ctrl),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.ovl       (ovl_vec[i]),
			.sel_info  (info_vec[i])
		);
	end

	always_comb begin
		sel_or = '0;
		for (int i = 0; i < rpt_pkg::MAX_ENTRIES; i++) begin
			sel_or = sel_or | info_vec[i];
		end
	end

	assign go             = (state_q == S_COMMIT) && (!out_valid_q || !out_stall);
	assign ctrl.find_en   = (state_q == S_FIND);
	// an overlap only holds back place and move
	assign ctrl.commit_en = go && (!ovl_q || bcast_q.cmd == rpt_pkg::CMD_REMOVE);
	assign in_stall       = (state_q != S_IDLE);

	always_comb begin
		place_ok  = 1'b0;
		remove_ok = 1'b0;
		case (bcast_q.cmd)
			rpt_pkg::CMD_PLACE: begin
				status_d = !found_q ? rpt_pkg::ST_FULL :
					(ovl_q ? rpt_pkg::ST_OVERLAP : rpt_pkg::ST_OK);
				place_ok = found_q && !ovl_q;
			end
			rpt_pkg::CMD_REMOVE: begin
				status_d  = found_q ? rpt_pkg::ST_OK : rpt_pkg::ST_MISS;
				remove_ok = found_q;
			end
			rpt_pkg::CMD_MOVE: begin
				status_d = !found_q ? rpt_pkg::ST_MISS :
					(ovl_q ? rpt_pkg::ST_OVERLAP : rpt_pkg::ST_OK);
			end
			default: begin
				status_d = found_q ? rpt_pkg::ST_OK : rpt_pkg::ST_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_FIND;
				S_FIND:   state_q <= S_CHECK;
				S_CHECK:  state_q <= S_COMMIT;
				S_COMMIT: begin
					if (go) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						if (place_ok) begin
							count_q <= count_q + 1'b1;
						end else if (remove_ok) begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			bcast_q.cmd <= rpt_pkg::cmd_t'(cmd);
			bcast_q.id  <= object_id;
			bcast_q.x   <= pos_x;
			bcast_q.y   <= pos_y;
			bcast_q.w   <= rect_width;
			bcast_q.h   <= rect_height;
		end
		if (state_q == S_FIND) begin
			found_q  <= chain[rpt_pkg::MAX_ENTRIES];
			sel_id_q <= sel_or.id;
		end
		// a move is tested with the size of the entry it moves
		if (state_q == S_CHECK) begin
			ovl_q <= |ovl_vec;
		end else if (state_q == S_FIND && bcast_q.cmd == rpt_pkg::CMD_MOVE) begin
			bcast_q.w <= sel_or.w;
			bcast_q.h <= sel_or.h;
		end
		if (go) begin
			status_q <= status_d;
			hit_id_q <= (bcast_q.cmd == rpt_pkg::CMD_QUERY && found_q) ? sel_id_q : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign hit_id      = hit_id_q;
	assign entry_count = count_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rpt_pkg::COUNT_BITS'(rpt_pkg::MAX_ENTRIES))
		else $error("entry count beyond table size");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_place_count: assert property (@(posedge clk) disable iff (!arst_n)
		go && place_ok |=> count_q == $past(count_q) + 1'b1)
		else $error("successful place did not bump count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		go && bcast_q.cmd == rpt_pkg::CMD_PLACE && !found_q |->
		count_q == rpt_pkg::COUNT_BITS'(rpt_pkg::MAX_ENTRIES))
		else $error("table reported full below capacity");

endmodule
